// File: hdl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants for the sparse row accumulator.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int COLS      = 1024;
    localparam int ROW_CAP   = 64;
    localparam int FRAC_BITS = 16;
    localparam int COL_W     = 10;
    localparam int SUM_W     = 48;
    localparam int POS_W     = 6;
    localparam int CNT_W     = 7;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef struct packed {
        logic init_clear;
        logic sort_step;
        logic emit_load;
        logic emit_empty;
        logic row_clear;
        logic [COL_W-1:0] sweep_col;
        logic [COL_W-1:0] scan_col;
    } sra_cmd_t;

    typedef struct packed {
        logic              term_busy;
        logic [CNT_W-1:0]  count;
        logic              col_occupied;
    } sra_stat_t;

endpackage

// File: hdl/sra_datapath.sv
// ----------------------------------------------------------------------------
// sra_datapath
// Product pipeline, accumulator RAM with forwarding, occupancy and column scan.
// ----------------------------------------------------------------------------
module sra_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        term_valid,
    input  logic [sra_pkg::COL_W-1:0]   term_col,
    input  logic signed [sra_pkg::VAL_W-1:0] term_a,
    input  logic signed [sra_pkg::VAL_W-1:0] term_b,
    input  sra_pkg::sra_cmd_t           cmd,
    output sra_pkg::sra_stat_t          stat,
    output logic signed [sra_pkg::SUM_W-1:0] rd_sum,
    output logic                        dropped
);
    // stage 1: multiply, occupancy read returns
    logic                              s1_v_reg;
    logic [sra_pkg::COL_W-1:0]         s1_col_reg;
    logic signed [sra_pkg::PROD_W-1:0] s1_prod_reg;
    // stage 2: occupancy decided, accumulator read issued
    logic                              s2_v_reg;
    logic                              s2_new_reg;
    logic [sra_pkg::COL_W-1:0]         s2_col_reg;
    logic signed [sra_pkg::SUM_W-1:0]  s2_prod_reg;
    // stage 3: add and write
    logic                              s3_v_reg;
    logic                              s3_new_reg;
    logic [sra_pkg::COL_W-1:0]         s3_col_reg;
    logic signed [sra_pkg::SUM_W-1:0]  s3_prod_reg;
    logic signed [sra_pkg::SUM_W-1:0]  rdata_reg;
    // last write, kept for forwarding
    logic                              wr_v_reg;
    logic [sra_pkg::COL_W-1:0]         wr_col_reg;
    logic signed [sra_pkg::SUM_W-1:0]  wr_sum_reg;

    logic signed [sra_pkg::SUM_W-1:0] acc_mem [sra_pkg::COLS];
    logic                             occ_mem [sra_pkg::COLS];
    logic                             occ_rd_reg;
    logic [sra_pkg::CNT_W-1:0]        count_reg;
    logic                             dropped_reg;

    logic signed [sra_pkg::SUM_W-1:0] old_sum;
    logic signed [sra_pkg::SUM_W:0]   add_full;
    logic signed [sra_pkg::SUM_W-1:0] sum_sat;
    logic                             s1_occ;
    logic                             s1_new;
    logic                             s1_drop;
    logic [sra_pkg::COL_W-1:0]        rd_addr;
    logic [sra_pkg::COL_W-1:0]        occ_addr;
    logic                             occ_we;
    logic [sra_pkg::COL_W-1:0]        occ_waddr;
    logic                             occ_wdata;

    always_ff @(posedge aclk) begin
        s1_prod_reg <= sra_pkg::PROD_W'(term_a * term_b);
        s1_col_reg  <= term_col;
        s2_col_reg  <= s1_col_reg;
        s2_prod_reg <= sra_pkg::SUM_W'(s1_prod_reg >>> sra_pkg::FRAC_BITS);
        s3_col_reg  <= s2_col_reg;
        s3_prod_reg <= s2_prod_reg;
        s3_new_reg  <= s2_new_reg;
        wr_col_reg  <= s3_col_reg;
        wr_sum_reg  <= sum_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            wr_v_reg <= 1'b0;
        end else begin
            s1_v_reg <= term_valid;
            s2_v_reg <= s1_v_reg && !s1_drop && (s1_occ || s1_new);
            s3_v_reg <= s2_v_reg;
            wr_v_reg <= s3_v_reg;
        end
    end

    // the term one ahead marks its column at the edge this read was taken
    assign s1_occ  = occ_rd_reg || (s2_v_reg && s2_col_reg == s1_col_reg);
    assign s1_new  = !s1_occ && (count_reg < sra_pkg::CNT_W'(sra_pkg::ROW_CAP));
    assign s1_drop = !s1_occ && !s1_new;

    always_ff @(posedge aclk) begin
        s2_new_reg <= s1_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (cmd.row_clear) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (s1_v_reg) begin
            if (s1_new) begin
                count_reg <= count_reg + 1'b1;
            end
            if (s1_drop) begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // occupancy: set for each new column, cleared by the init pass and as each column is emitted
    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = cmd.sweep_col;
        occ_wdata = 1'b0;
        if (cmd.init_clear || cmd.emit_load) begin
            occ_we = 1'b1;
        end else if (s1_v_reg && s1_new) begin
            occ_we    = 1'b1;
            occ_waddr = s1_col_reg;
            occ_wdata = 1'b1;
        end
    end

    assign occ_addr = term_valid ? term_col : cmd.scan_col;

    always_ff @(posedge aclk) begin
        if (occ_we) begin
            occ_mem[occ_waddr] <= occ_wdata;
        end
        occ_rd_reg <= occ_mem[occ_addr];
    end

    assign rd_addr = (cmd.sort_step || !s2_v_reg) ? cmd.sweep_col : s2_col_reg;

    always_ff @(posedge aclk) begin
        if (s3_v_reg) begin
            acc_mem[s3_col_reg] <= sum_sat;
        end
        rdata_reg <= acc_mem[rd_addr];
    end

    always_comb begin
        if (wr_v_reg && wr_col_reg == s3_col_reg) begin
            old_sum = wr_sum_reg;
        end else begin
            old_sum = rdata_reg;
        end
        if (s3_new_reg) begin
            add_full = {s3_prod_reg[sra_pkg::SUM_W-1], s3_prod_reg};
        end else begin
            add_full = {old_sum[sra_pkg::SUM_W-1], old_sum}
                     + {s3_prod_reg[sra_pkg::SUM_W-1], s3_prod_reg};
        end
        if (add_full[sra_pkg::SUM_W] != add_full[sra_pkg::SUM_W-1]) begin
            sum_sat = add_full[sra_pkg::SUM_W] ? sra_pkg::SUM_MIN : sra_pkg::SUM_MAX;
        end else begin
            sum_sat = add_full[sra_pkg::SUM_W-1:0];
        end
    end

    assign rd_sum            = rdata_reg;
    assign dropped           = dropped_reg;
    assign stat.term_busy    = s1_v_reg || s2_v_reg || s3_v_reg;
    assign stat.count        = count_reg;
    assign stat.col_occupied = occ_rd_reg;

`ifndef NO_ASSERTIONS
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= sra_pkg::CNT_W'(sra_pkg::ROW_CAP))
        else $error("distinct count above capacity");
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        dropped_reg |-> count_reg == sra_pkg::CNT_W'(sra_pkg::ROW_CAP))
        else $error("term dropped below capacity");
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_clear |=> count_reg == '0)
        else $error("row clear left columns");
`endif
endmodule

// File: hdl/sra_controller.sv
// ----------------------------------------------------------------------------
// sra_controller
// Sequences term intake, ascending column sweep and row emission.
// ----------------------------------------------------------------------------
module sra_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_fire,
    input  logic                 s_row_end,
    input  logic                 out_free,
    input  sra_pkg::sra_stat_t   stat,
    output sra_pkg::sra_cmd_t    cmd,
    output logic                 in_ready,
    output logic [sra_pkg::POS_W-1:0] pos,
    output logic                 is_last
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;
    localparam logic [2:0] ST_INIT  = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [sra_pkg::COL_W-1:0]  col_reg, col_next;
    logic [sra_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic [sra_pkg::CNT_W-1:0]  total_reg, total_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            col_reg   <= '0;
            idx_reg   <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
            total_reg <= total_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        total_next = total_reg;
        cmd        = '0;
        cmd.sweep_col = col_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.init_clear = 1'b1;
                col_next = col_reg + 1'b1;
                if (col_reg == sra_pkg::COL_W'(sra_pkg::COLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_fire && s_row_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.term_busy) begin
                    col_next   = '0;
                    idx_next   = '0;
                    total_next = stat.count;
                    state_next = (stat.count == '0) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.col_occupied) begin
                    cmd.sort_step = 1'b1;
                    state_next = ST_READ;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (total_reg == '0) begin
                        cmd.emit_empty = 1'b1;
                        state_next = ST_CLEAR;
                    end else begin
                        cmd.emit_load = 1'b1;
                        idx_next = idx_reg + 1'b1;
                        col_next = col_reg + 1'b1;
                        state_next = (idx_reg + 1'b1 == total_reg) ? ST_CLEAR : ST_SCAN;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.row_clear = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // occupancy read address for the next cycle's column
        cmd.scan_col = col_next;
    end

    assign pos     = idx_reg[sra_pkg::POS_W-1:0];
    assign is_last = (idx_reg + 1'b1 == total_reg);

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input taken outside idle");
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> idx_reg < total_reg)
        else $error("emitted more columns than counted");
    a_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_empty || (cmd.emit_load && is_last)) |=> cmd.row_clear)
        else $error("row not cleared after last result");
`endif
endmodule

// File: hdl/sparse_row_accumulator.sv
// ----------------------------------------------------------------------------
// sparse_row_accumulator
// Dense sparse accumulator for row-wise sparse matrix multiply.
// ----------------------------------------------------------------------------
// After reset the input stays not ready while the occupancy map is cleared.
// Transactions without row end are taken one per cycle and the product
// pipeline keeps running. A row-end transaction holds the input for a drain
// of the product pipeline, a scan of the occupancy map from column 0 up to
// the highest occupied column (one column per cycle, plus READ and EMIT per
// nonzero; EMIT waits for a free output register) and a row clear. Results
// leave through an output register; an empty row gives one result.
module sparse_row_accumulator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] has_term, [10:1] column, [42:11] left_value, [74:43] right_value
    input  logic [79:0] s_tdata,
    input  logic        s_tlast,   // row_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // [9:0] out_column, [57:10] sum_value, [63:58] position
    output logic [63:0] m_tdata,
    output logic        m_tlast,   // last
    // [0] empty_row, [1] overflow
    output logic [1:0]  m_tuser
);
    sra_pkg::sra_cmd_t  cmd;
    sra_pkg::sra_stat_t stat;
    logic               s_fire;
    logic               out_free;
    logic signed [sra_pkg::SUM_W-1:0] rd_sum;
    logic               dropped;
    logic [sra_pkg::POS_W-1:0] pos;
    logic               is_last;
    logic               mv_reg;
    logic [63:0]        mdata_reg;
    logic               mlast_reg;
    logic [1:0]         muser_reg;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;

    sra_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_fire    (s_fire),
        .s_row_end (s_tlast),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .pos       (pos),
        .is_last   (is_last)
    );

    sra_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .term_valid (s_fire && s_tdata[0]),
        .term_col   (s_tdata[10:1]),
        .term_a     (s_tdata[42:11]),
        .term_b     (s_tdata[74:43]),
        .cmd        (cmd),
        .stat       (stat),
        .rd_sum     (rd_sum),
        .dropped    (dropped)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.emit_load || cmd.emit_empty) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            mdata_reg <= {pos, rd_sum, cmd.sweep_col};
            mlast_reg <= is_last;
            muser_reg <= {dropped, 1'b0};
        end else if (cmd.emit_empty) begin
            mdata_reg <= '0;
            mlast_reg <= 1'b1;
            muser_reg <= {dropped, 1'b1};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load || cmd.emit_empty) |-> out_free)
        else $error("result register overwritten");
    a_quiet_in: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_tready |=> $stable(mdata_reg))
        else $error("stalled result changed");
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("empty row result not last");
`endif
endmodule
